>>> rtl/core/rfe_pkg.sv
// Shared constants, types and helpers for the RGB565 edge feather core.
package rfe_pkg;

  localparam int unsigned NumPx     = 10;
  localparam int unsigned NumLanes  = 9;
  localparam int unsigned Feather   = 6;
  localparam logic [11:0] EdgeBase  = 12'd657;
  localparam logic [11:0] VisRight  = 12'd660;
  localparam logic [2:0]  EdgeIdx0  = 3'd6;

  localparam logic [1:0] RegBarTop     = 2'd0;
  localparam logic [1:0] RegScreenH    = 2'd1;
  localparam logic [1:0] RegSurfaceW   = 2'd2;
  localparam logic [1:0] RegSurfaceH   = 2'd3;

  typedef logic [15:0] pix_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  // Weight of the pixel's own color at distance d from the edge.
  function automatic logic [7:0] feather_w(input logic [2:0] d);
    logic [7:0] w;
    case (d)
      3'd1:    w = 8'd43;
      3'd2:    w = 8'd85;
      3'd3:    w = 8'd128;
      3'd4:    w = 8'd170;
      3'd5:    w = 8'd213;
      3'd6:    w = 8'd255;
      default: w = 8'd255;
    endcase
    return w;
  endfunction

  // Rounded blend of one channel, divided by 255 through a shift form.
  function automatic logic [5:0] mix_ch(input logic [5:0] own, input logic [5:0] edg,
                                        input logic [7:0] w);
    logic [14:0] x;
    logic [14:0] q;
    x = 15'(own) * 15'(w) + 15'(edg) * 15'(8'd255 - w) + 15'd127;
    q = (x + 15'd1 + (x >> 8)) >> 8;
    return q[5:0];
  endfunction

endpackage

>>> rtl/core/rgb565_parabolic_edge_feather_core.sv
// Top level: config registers, four-stage pipeline, lanes and merged output register.
//
//  channel | signals                                         | accepted when
//  in      | in_valid_i, in_ready_o, row_index_i, pxNNN_in_i | in_valid_i & in_ready_o
//  out     | out_valid_o, out_ready_i, pxNNN_out_o, row_blended_o | out_valid_o & out_ready_i
//  cfg     | cfg_we_i, cfg_idx_i, cfg_data_i                 | cfg_we_i
//
// One beat per clock sustained while out_ready_i is high; out_valid_o is driven by the last stage valid.
// Stages: span/position, two 13x13 products, rounding compare, nine blend lanes.
// Each stage holds only while it is full and the next one is held; bubbles collapse.
// Reset clears stage valids and loads register defaults.
module rgb565_parabolic_edge_feather_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [11:0] row_index_i,
  input  logic [15:0] px651_in_i,
  input  logic [15:0] px652_in_i,
  input  logic [15:0] px653_in_i,
  input  logic [15:0] px654_in_i,
  input  logic [15:0] px655_in_i,
  input  logic [15:0] px656_in_i,
  input  logic [15:0] px657_in_i,
  input  logic [15:0] px658_in_i,
  input  logic [15:0] px659_in_i,
  input  logic [15:0] px660_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] px651_out_o,
  output logic [15:0] px652_out_o,
  output logic [15:0] px653_out_o,
  output logic [15:0] px654_out_o,
  output logic [15:0] px655_out_o,
  output logic [15:0] px656_out_o,
  output logic [15:0] px657_out_o,
  output logic [15:0] px658_out_o,
  output logic [15:0] px659_out_o,
  output logic [15:0] px660_out_o,
  output logic        row_blended_o
);

  logic [12:0] bar_top_q;
  logic [11:0] screen_h_q, surface_w_q, surface_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bar_top_q   <= 13'd0;
      screen_h_q  <= 12'd600;
      surface_w_q <= 12'd800;
      surface_h_q <= 12'd600;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rfe_pkg::RegBarTop:   bar_top_q   <= cfg_data_i;
        rfe_pkg::RegScreenH:  screen_h_q  <= cfg_data_i[11:0];
        rfe_pkg::RegSurfaceW: surface_w_q <= cfg_data_i[11:0];
        rfe_pkg::RegSurfaceH: surface_h_q <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // stage valids and per-stage advance
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  rfe_pkg::stage_en_t en;

  assign rdy4 = !v4_q || out_ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  assign en.s1 = rdy1;
  assign en.s2 = rdy2;
  assign en.s3 = rdy3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  rfe_pkg::pix_t px_in [rfe_pkg::NumPx];
  rfe_pkg::pix_t px1_q [rfe_pkg::NumPx];
  rfe_pkg::pix_t px2_q [rfe_pkg::NumPx];
  rfe_pkg::pix_t px3_q [rfe_pkg::NumPx];
  rfe_pkg::pix_t px4_d [rfe_pkg::NumPx];
  rfe_pkg::pix_t px4_q [rfe_pkg::NumPx];

  assign px_in[0] = px651_in_i;
  assign px_in[1] = px652_in_i;
  assign px_in[2] = px653_in_i;
  assign px_in[3] = px654_in_i;
  assign px_in[4] = px655_in_i;
  assign px_in[5] = px656_in_i;
  assign px_in[6] = px657_in_i;
  assign px_in[7] = px658_in_i;
  assign px_in[8] = px659_in_i;
  assign px_in[9] = px660_in_i;

  always_ff @(posedge clk_i) begin
    if (rdy1) px1_q <= px_in;
    if (rdy2) px2_q <= px1_q;
    if (rdy3) px3_q <= px2_q;
  end

  logic [1:0] ins;
  logic       blend;

  rfe_edge u_edge (
    .clk_i       (clk_i),
    .en_i        (en),
    .row_i       (row_index_i),
    .bar_top_i   (bar_top_q),
    .screen_h_i  (screen_h_q),
    .surface_w_i (surface_w_q),
    .surface_h_i (surface_h_q),
    .ins_o       (ins),
    .blend_o     (blend)
  );

  // edge pixel sits at index 6 + ins
  logic [3:0]    edge_idx;
  rfe_pkg::pix_t edge_px;

  assign edge_idx = {1'b0, rfe_pkg::EdgeIdx0} + {2'b0, ins};

  always_comb begin
    case (ins)
      2'd0:    edge_px = px3_q[6];
      2'd1:    edge_px = px3_q[7];
      2'd2:    edge_px = px3_q[8];
      2'd3:    edge_px = px3_q[9];
      default: edge_px = px3_q[6];
    endcase
  end

  for (genvar j = 0; j < rfe_pkg::NumLanes; j++) begin : g_lane
    logic [3:0] lane_dist;
    logic       act;
    assign lane_dist = edge_idx - 4'(j);
    assign act  = blend && (edge_idx > 4'(j)) && (lane_dist <= 4'(rfe_pkg::Feather));
    rfe_lane u_lane (
      .own_i     (px3_q[j]),
      .edge_px_i (edge_px),
      .dist_i    (lane_dist[2:0]),
      .act_i     (act),
      .px_o      (px4_d[j])
    );
  end

  // rightmost column is never left of the edge
  assign px4_d[9] = px3_q[9];

  logic blended_q;

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      px4_q     <= px4_d;
      blended_q <= blend;
    end
  end

  assign out_valid_o   = v4_q;
  assign row_blended_o = blended_q;
  assign px651_out_o   = px4_q[0];
  assign px652_out_o   = px4_q[1];
  assign px653_out_o   = px4_q[2];
  assign px654_out_o   = px4_q[3];
  assign px655_out_o   = px4_q[4];
  assign px656_out_o   = px4_q[5];
  assign px657_out_o   = px4_q[6];
  assign px658_out_o   = px4_q[7];
  assign px659_out_o   = px4_q[8];
  assign px660_out_o   = px4_q[9];

endmodule

>>> rtl/core/rfe_edge.sv
// Pipelined edge column search: band span, parabola products and rounding compare.
module rfe_edge (
  input  logic                clk_i,
  input  rfe_pkg::stage_en_t  en_i,
  input  logic [11:0]         row_i,
  input  logic [12:0]         bar_top_i,
  input  logic [11:0]         screen_h_i,
  input  logic [11:0]         surface_w_i,
  input  logic [11:0]         surface_h_i,
  output logic [1:0]          ins_o,
  output logic                blend_o
);

  logic signed [14:0] y_s, bt_s, sh_s, span_s;
  logic               pass_d;
  logic               pass_q, sp_ok_q;
  logic [12:0]        span_q, pos_q;
  logic               pass2_q, sp_ok2_q;
  logic [25:0]        prod_q, den_q;
  logic [30:0]        num2, lhs, t2, t4, t6;
  logic [1:0]         prot;
  logic [11:0]        edge_col;
  logic [1:0]         ins_q;
  logic               blend_q;

  assign y_s    = {3'b000, row_i};
  assign bt_s   = {{2{bar_top_i[12]}}, bar_top_i};
  assign sh_s   = {3'b000, screen_h_i};
  assign span_s = sh_s - bt_s - 15'sd1;

  assign pass_d = (surface_w_i > rfe_pkg::VisRight) && (surface_h_i != 12'd0) &&
                  (y_s >= bt_s) && (row_i < screen_h_i) && (row_i < surface_h_i);

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      pass_q  <= pass_d;
      sp_ok_q <= (span_s > 15'sd0);
      span_q  <= span_s[12:0];
      pos_q   <= 13'(y_s - bt_s);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      pass2_q  <= pass_q;
      sp_ok2_q <= sp_ok_q;
      prod_q   <= pos_q * (span_q - pos_q);
      den_q    <= span_q * span_q;
    end
  end

  // prot >= k when 12*prod + floor(den/2) >= k*den; compare at twice the scale
  assign num2 = {prod_q, 5'b0} - {2'b0, prod_q, 3'b0};
  assign lhs  = num2 + {5'b0, den_q} - {30'b0, den_q[0]};
  assign t2   = {4'b0, den_q, 1'b0};
  assign t4   = {3'b0, den_q, 2'b0};
  assign t6   = t4 + t2;

  always_comb begin
    prot = 2'd0;
    if (sp_ok2_q) begin
      if (lhs >= t6)      prot = 2'd3;
      else if (lhs >= t4) prot = 2'd2;
      else if (lhs >= t2) prot = 2'd1;
    end
  end

  assign edge_col = rfe_pkg::EdgeBase + {10'b0, prot};

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      ins_q   <= prot;
      blend_q <= pass2_q && (edge_col < surface_w_i);
    end
  end

  assign ins_o   = ins_q;
  assign blend_o = blend_q;

endmodule

>>> rtl/core/rfe_lane.sv
// One blend lane: feathers a single column toward the edge pixel.
module rfe_lane (
  input  rfe_pkg::pix_t own_i,
  input  rfe_pkg::pix_t edge_px_i,
  input  logic [2:0]    dist_i,
  input  logic          act_i,
  output rfe_pkg::pix_t px_o
);

  logic [7:0] w;
  logic [5:0] r, g, b;

  assign w = rfe_pkg::feather_w(dist_i);
  assign r = rfe_pkg::mix_ch({1'b0, own_i[15:11]}, {1'b0, edge_px_i[15:11]}, w);
  assign g = rfe_pkg::mix_ch(own_i[10:5], edge_px_i[10:5], w);
  assign b = rfe_pkg::mix_ch({1'b0, own_i[4:0]}, {1'b0, edge_px_i[4:0]}, w);

  assign px_o = act_i ? {r[4:0], g, b[4:0]} : own_i;

endmodule

>>> tb/rgb565_parabolic_edge_feather_core_tb.sv
// Self-checking testbench for the RGB565 parabolic edge feather core.
`timescale 1ns / 1ps

module rgb565_parabolic_edge_feather_core_tb;

  typedef struct {
    logic [11:0]   row;
    rfe_pkg::pix_t px [10];
  } row_beat_t;

  typedef struct {
    rfe_pkg::pix_t px [10];
    logic          blended;
  } feathered_row_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_we_i = 1'b0;
  logic [1:0]    cfg_idx_i = rfe_pkg::RegBarTop;
  logic [12:0]   cfg_data_i = '0;
  logic          in_valid_i = 1'b0;
  logic          in_ready_o;
  logic [11:0]   row_index_i = '0;
  rfe_pkg::pix_t pin [10];
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  rfe_pkg::pix_t pout [10];
  logic          row_blended_o;

  initial for (int i = 0; i < 10; i++) pin[i] = '0;

  always #5 clk_i = ~clk_i;

  rgb565_parabolic_edge_feather_core dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .row_index_i,
    .px651_in_i(pin[0]), .px652_in_i(pin[1]), .px653_in_i(pin[2]),
    .px654_in_i(pin[3]), .px655_in_i(pin[4]), .px656_in_i(pin[5]),
    .px657_in_i(pin[6]), .px658_in_i(pin[7]), .px659_in_i(pin[8]),
    .px660_in_i(pin[9]),
    .out_valid_o, .out_ready_i,
    .px651_out_o(pout[0]), .px652_out_o(pout[1]), .px653_out_o(pout[2]),
    .px654_out_o(pout[3]), .px655_out_o(pout[4]), .px656_out_o(pout[5]),
    .px657_out_o(pout[6]), .px658_out_o(pout[7]), .px659_out_o(pout[8]),
    .px660_out_o(pout[9]), .row_blended_o
  );

  // Register shadow
  int bar_top_q = 0;
  int screen_h_q = 600;
  int surface_w_q = 800;
  int surface_h_q = 600;

  row_beat_t      pending_rows[$];
  feathered_row_t expected_rows[$];
  int  errors = 0;
  bit  idle_on = 1'b1;
  int  hold_off = 0;
  int  in_gap = 0;
  int  out_gap = 0;

  function automatic int edge_col(int y);
    longint span, pos, num, den, prot;
    if (y < bar_top_q) return 660;
    if (screen_h_q <= bar_top_q) return 657;
    span = longint'(screen_h_q) - bar_top_q - 1;
    if (span <= 0) return 657;
    pos = longint'(y) - bar_top_q;
    if (pos < 0) pos = 0;
    if (pos > span) pos = span;
    den = span * span;
    num = 12 * pos * (span - pos);
    prot = (num + den / 2) / den;
    if (prot > 3) prot = 3;
    return 657 + int'(prot);
  endfunction

  function automatic int unsigned mix(int unsigned own, int unsigned e, int unsigned w);
    return (own * w + e * (255 - w) + 127) / 255;
  endfunction

  function automatic feathered_row_t feather_row(row_beat_t b);
    feathered_row_t r;
    int y, ec;
    int unsigned w, o, e;
    y = b.row;
    r.px = b.px;
    r.blended = 1'b0;
    if (surface_w_q > 660 && surface_h_q > 0 && y >= bar_top_q && y < screen_h_q &&
        y < surface_h_q) begin
      ec = edge_col(y);
      if (ec < surface_w_q) begin
        e = b.px[ec - 651];
        for (int d = 1; d <= 6; d++) begin
          w = (d * 255 + 3) / 6;
          o = b.px[ec - d - 651];
          r.px[ec - d - 651] = rfe_pkg::pix_t'((mix(o >> 11, e >> 11, w) << 11) |
                               (mix((o >> 5) & 'h3F, (e >> 5) & 'h3F, w) << 5) |
                               mix(o & 'h1F, e & 'h1F, w));
        end
        r.blended = 1'b1;
      end
    end
    return r;
  endfunction

  // Driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        if (pending_rows.size() > 0) void'(pending_rows.pop_front());
      end
      if (in_valid_i && !in_ready_o) begin
        // hold
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        in_gap <= $urandom_range(1, 13) - 1;
        in_valid_i <= 1'b0;
      end else if (pending_rows.size() > 0) begin
        in_valid_i  <= 1'b1;
        row_index_i <= pending_rows[0].row;
        for (int i = 0; i < 10; i++) pin[i] <= pending_rows[0].px[i];
        expected_rows.push_back(feather_row(pending_rows[0]));
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor and receiver stall
  always @(posedge clk_i) begin
    feathered_row_t x;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_rows.size() == 0) begin
          $error("result with no expectation");
          errors++;
        end else begin
          x = expected_rows.pop_front();
          for (int i = 0; i < 10; i++)
            if (pout[i] !== x.px[i]) begin
              $error("px%0d_out exp %h got %h", 651 + i, x.px[i], pout[i]);
              errors++;
            end
          if (row_blended_o !== x.blended) begin
            $error("row_blended exp %b got %b", x.blended, row_blended_o);
            errors++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ready_i <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(1, 13) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic row_beat_t rand_row(int lo, int hi);
    row_beat_t b;
    b.row = 12'($urandom_range(lo, hi));
    for (int i = 0; i < 10; i++) b.px[i] = rfe_pkg::pix_t'($urandom);
    return b;
  endfunction

  task automatic write_reg(logic [1:0] idx, int val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= 13'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      rfe_pkg::RegBarTop:   bar_top_q = (val & 'h1000) ? (val & 'h1FFF) - 8192 : (val & 'h1FFF);
      rfe_pkg::RegScreenH:  screen_h_q = val & 'hFFF;
      rfe_pkg::RegSurfaceW: surface_w_q = val & 'hFFF;
      default:              surface_h_q = val & 'hFFF;
    endcase
  endtask

  task automatic drain;
    wait (pending_rows.size() == 0 && !in_valid_i && expected_rows.size() == 0);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_cfg(int bt, int sh, int sw, int shh);
    write_reg(rfe_pkg::RegBarTop, bt);
    write_reg(rfe_pkg::RegScreenH, sh);
    write_reg(rfe_pkg::RegSurfaceW, sw);
    write_reg(rfe_pkg::RegSurfaceH, shh);
  endtask

  task automatic queue_rows(int n, int lo, int hi);
    for (int i = 0; i < n; i++) pending_rows.push_back(rand_row(lo, hi));
  endtask

  initial begin
    row_beat_t b;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed: reset config, band ends and middle, pixel extremes
    foreach (b.px[i]) b.px[i] = 16'hFFFF;
    b.px[6] = 16'h0000;
    b.row = 12'd0;    pending_rows.push_back(b);
    b.row = 12'd299;  pending_rows.push_back(b);
    b.row = 12'd599;  pending_rows.push_back(b);
    b.row = 12'd600;  pending_rows.push_back(b);
    b.row = 12'd4095; pending_rows.push_back(b);
    foreach (b.px[i]) b.px[i] = 16'h0000;
    b.px[9] = 16'hFFFF; b.px[7] = 16'hFFFF;
    b.row = 12'd300;  pending_rows.push_back(b);
    b.row = 12'd150;  pending_rows.push_back(b);
    queue_rows(6, 0, 4095);
    drain();
    // Narrow surface, empty surface, single-row band, negative top
    set_cfg(0, 600, 660, 600);   queue_rows(4, 0, 700);   drain();
    set_cfg(0, 600, 659, 600);   queue_rows(4, 0, 700);   drain();
    set_cfg(0, 600, 661, 0);     queue_rows(4, 0, 700);   drain();
    set_cfg(100, 101, 4095, 4095); queue_rows(3, 99, 102); drain();
    set_cfg(100, 100, 4095, 4095); queue_rows(3, 99, 102); drain();
    set_cfg(8191, 4095, 4095, 4095); queue_rows(4, 0, 4095); drain();
    // Random phases with extremes
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: set_cfg(4096, 4095, 4095, 4095);
        1: set_cfg(4095, 4095, 4095, 4095);
        2: set_cfg(0, 0, 0, 0);
        3: set_cfg(0, 4095, 658, 4095);
        default: set_cfg($urandom_range(0, 600) | (($urandom_range(0, 5) == 0) ? 'h1000 : 0),
                         $urandom_range(0, 1200), $urandom_range(600, 4095),
                         $urandom_range(0, 1200));
      endcase
      if (ph == 6) hold_off = 200;
      if (ph == 11) idle_on = 1'b0;
      queue_rows(100, 0, (ph < 4) ? 4095 : 1300);
      drain();
    end
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/rfe_pkg.sv
rtl/core/rfe_edge.sv
rtl/core/rfe_lane.sv
rtl/core/rgb565_parabolic_edge_feather_core.sv
tb/rgb565_parabolic_edge_feather_core_tb.sv
